@@ rtl/bsfe_pkg.sv @@
package bsfe_pkg;

  // input opcodes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CHECK_MODE   = 2'd0;
  localparam logic [1:0] CFG_ESCAPE_BODY  = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_CHECK = 2'd2;

  // framing bytes
  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] command;
    logic [11:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
    logic       length_mismatch;
  } out_item_t;

  typedef struct packed {
    logic check_mode;
    logic escape_body;
    logic escape_check;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // one classified command for the byte sequencer
  typedef struct packed {
    kind_t       kind;
    logic [15:0] command;
    logic [12:0] hdr_len;
    logic [7:0]  data;
    logic        mism;
    logic        pad;
  } qent_t;

  // bitwise crc over one byte, msb first, data bit xored after the shift
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        top;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      top = c[15];
      c = {c[14:0], 1'b0};
      if (top) c = c ^ CRC_POLY;
      if (b[i]) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

endpackage

@@ rtl/bsfe_front.sv @@
module bsfe_front #(
  parameter int MAX_PAYLOAD = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bsfe_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output bsfe_pkg::qent_t   q_ent
);
  import bsfe_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int CMP_W = (CNT_W > 12) ? CNT_W : 12;

  logic             inf_r, inf_nxt;
  logic [11:0]      dlen_r, dlen_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // classify the transaction and track frame bookkeeping
  always_comb begin
    inf_nxt  = inf_r;
    dlen_nxt = dlen_r;
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    q_push   = 1'b0;
    q_ent    = '0;
    q_ent.command = in_data.command;
    q_ent.data    = in_data.data_byte;
    q_ent.hdr_len = ({1'b0, in_data.payload_length} + 13'd1) & ~13'd1;
    q_ent.mism    = drop_r || (CMP_W'(cnt_r) != CMP_W'(dlen_r));
    q_ent.pad     = cnt_r[0];
    if (accept) begin
      case (in_data.opcode)
        OP_START: begin
          q_push     = 1'b1;
          q_ent.kind = KIND_START;
          inf_nxt    = 1'b1;
          dlen_nxt   = in_data.payload_length;
          cnt_nxt    = '0;
          drop_nxt   = 1'b0;
        end
        OP_PAYLOAD: begin
          if (inf_r) begin
            if (cnt_r >= CNT_W'(MAX_PAYLOAD)) begin
              drop_nxt = 1'b1;
            end else begin
              q_push     = 1'b1;
              q_ent.kind = KIND_DATA;
              cnt_nxt    = cnt_r + CNT_W'(1);
            end
          end
        end
        OP_END: begin
          if (inf_r) begin
            q_push     = 1'b1;
            q_ent.kind = KIND_END;
            inf_nxt    = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inf_r  <= 1'b0;
      dlen_r <= '0;
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      inf_r  <= inf_nxt;
      dlen_r <= dlen_nxt;
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

@@ rtl/bsfe_queue.sv @@
module bsfe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bsfe_pkg::qent_t push_ent,
  input  logic            pop,
  output bsfe_pkg::qent_t head,
  output logic            full,
  output logic            empty
);
  import bsfe_pkg::*;

  qent_t            mem_r [QDEPTH];
  logic [QA_W-1:0]  wp_r, wp_nxt;
  logic [QA_W-1:0]  rp_r, rp_nxt;
  logic [QC_W-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == QC_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  // pointer and fill tracking
  always_comb begin
    wp_nxt  = push ? wp_r + QA_W'(1) : wp_r;
    rp_nxt  = pop  ? rp_r + QA_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QC_W'(1);
    if (pop && !push) cnt_nxt = cnt_r - QC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_ent;
    end
  end

endmodule

@@ rtl/bsfe_back.sv @@
module bsfe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bsfe_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  bsfe_pkg::qent_t    q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output bsfe_pkg::out_item_t out_data
);
  import bsfe_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE       = 11'b00000000001,
    ST_FLAG_OPEN  = 11'b00000000010,
    ST_CMD_HI     = 11'b00000000100,
    ST_CMD_LO     = 11'b00000001000,
    ST_LEN_HI     = 11'b00000010000,
    ST_LEN_LO     = 11'b00000100000,
    ST_DATA       = 11'b00001000000,
    ST_PAD        = 11'b00010000000,
    ST_CHK_HI     = 11'b00100000000,
    ST_CHK_LO     = 11'b01000000000,
    ST_FLAG_CLOSE = 11'b10000000000
  } bstate_t;

  bstate_t     state_r, state_nxt, seq_nxt, head_st;
  qent_t       cur_r, cur_nxt;
  logic        esc2_r, esc2_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [8:0]  pend_r, pend_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   od_r, od_nxt;

  logic        load, active, step_done;
  logic [7:0]  raw, obyte;
  logic        feed_st, clear_st, esc_en, last_st, done_st, mism_st;
  logic [16:0] fold1;
  logic [15:0] fold2, chk;

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign load      = !ov_r || out_ready;
  assign active    = (state_r != ST_IDLE);

  // check value: crc or complemented folded word sum
  assign fold1 = {1'b0, sum_r[31:16]} + {1'b0, sum_r[15:0]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
  assign chk   = cfg.check_mode ? ~fold2 : crc_r;

  // first step for the entry at the queue head
  always_comb begin
    case (q_head.kind)
      KIND_START: head_st = ST_FLAG_OPEN;
      KIND_DATA:  head_st = ST_DATA;
      KIND_END:   head_st = q_head.pad ? ST_PAD : ST_CHK_HI;
      default:    head_st = ST_IDLE;
    endcase
  end

  // byte source and attributes of the current step
  always_comb begin
    raw      = FLAG_BYTE;
    feed_st  = 1'b0;
    clear_st = 1'b0;
    esc_en   = 1'b0;
    last_st  = 1'b0;
    done_st  = 1'b0;
    mism_st  = 1'b0;
    seq_nxt  = ST_IDLE;
    case (state_r)
      ST_FLAG_OPEN: begin
        clear_st = 1'b1;
        seq_nxt  = ST_CMD_HI;
      end
      ST_CMD_HI: begin
        raw     = cur_r.command[15:8];
        feed_st = 1'b1;
        esc_en  = cfg.escape_body;
        seq_nxt = ST_CMD_LO;
      end
      ST_CMD_LO: begin
        raw     = cur_r.command[7:0];
        feed_st = 1'b1;
        esc_en  = cfg.escape_body;
        seq_nxt = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        raw     = {3'd0, cur_r.hdr_len[12:8]};
        feed_st = 1'b1;
        esc_en  = cfg.escape_body;
        seq_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        raw     = cur_r.hdr_len[7:0];
        feed_st = 1'b1;
        esc_en  = cfg.escape_body;
        last_st = 1'b1;
      end
      ST_DATA: begin
        raw     = cur_r.data;
        feed_st = 1'b1;
        esc_en  = cfg.escape_body;
        last_st = 1'b1;
      end
      ST_PAD: begin
        raw     = 8'h00;
        feed_st = 1'b1;
        mism_st = cur_r.mism;
        seq_nxt = ST_CHK_HI;
      end
      ST_CHK_HI: begin
        raw     = chk[15:8];
        esc_en  = cfg.escape_body && cfg.escape_check;
        mism_st = cur_r.mism;
        seq_nxt = ST_CHK_LO;
      end
      ST_CHK_LO: begin
        raw     = chk[7:0];
        esc_en  = cfg.escape_body && cfg.escape_check;
        mism_st = cur_r.mism;
        seq_nxt = ST_FLAG_CLOSE;
      end
      ST_FLAG_CLOSE: begin
        done_st = 1'b1;
        last_st = 1'b1;
        mism_st = cur_r.mism;
      end
      default: begin
      end
    endcase
  end

  // sequencer, escaping and check accumulation
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    esc2_nxt  = esc2_r;
    crc_nxt   = crc_r;
    sum_nxt   = sum_r;
    pend_nxt  = pend_r;
    ov_nxt    = load ? 1'b0 : ov_r;
    od_nxt    = od_r;
    q_pop     = 1'b0;
    step_done = 1'b0;
    obyte     = raw;
    if (load && active) begin
      ov_nxt = 1'b1;
      if (esc2_r) begin
        obyte     = raw ^ ESC_XOR;
        esc2_nxt  = 1'b0;
        step_done = 1'b1;
      end else begin
        if (feed_st) begin
          crc_nxt = crc_byte(crc_r, raw);
          if (pend_r[8]) begin
            sum_nxt  = sum_r + {16'd0, pend_r[7:0], raw};
            pend_nxt = '0;
          end else begin
            pend_nxt = {1'b1, raw};
          end
        end
        if (esc_en && (raw == FLAG_BYTE || raw == ESC_BYTE)) begin
          obyte    = ESC_BYTE;
          esc2_nxt = 1'b1;
        end else begin
          step_done = 1'b1;
        end
      end
      if (clear_st) begin
        crc_nxt  = '0;
        sum_nxt  = '0;
        pend_nxt = '0;
      end
      od_nxt.out_byte        = obyte;
      od_nxt.run_last        = step_done && last_st;
      od_nxt.frame_done      = done_st;
      od_nxt.length_mismatch = mism_st;
      if (step_done) begin
        if (last_st) begin
          if (!q_empty) begin
            q_pop     = 1'b1;
            cur_nxt   = q_head;
            state_nxt = head_st;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = seq_nxt;
        end
      end
    end else if (!active && !q_empty) begin
      q_pop     = 1'b1;
      cur_nxt   = q_head;
      state_nxt = head_st;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      esc2_r  <= 1'b0;
      ov_r    <= 1'b0;
      crc_r   <= '0;
      sum_r   <= '0;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      esc2_r  <= esc2_nxt;
      ov_r    <= ov_nxt;
      crc_r   <= crc_nxt;
      sum_r   <= sum_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    od_r  <= od_nxt;
  end

endmodule

@@ rtl/byte_stuffed_frame_encoder.sv @@
// path of a transaction when idle: command queue, sequencer state, then output register
// throughput: one output byte per cycle from the byte sequencer while out_ready is high;
// a transaction gives 0 to 8 bytes, and a payload byte gives one byte, or two when escaped
// a four-entry command queue lets input transactions arrive while bytes are still going out
// reset: synchronous, active low; clears frame state, queue and check, config to
// check_mode 0, escape_body 1, escape_check 1
module byte_stuffed_frame_encoder #(
  parameter int MAX_PAYLOAD = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsfe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bsfe_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic                cfg_wdata
);
  import bsfe_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push, q_pop, q_full, q_empty;
  qent_t q_ent, q_head;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CHECK_MODE:   cfg_nxt.check_mode   = cfg_wdata;
        CFG_ESCAPE_BODY:  cfg_nxt.escape_body  = cfg_wdata;
        CFG_ESCAPE_CHECK: cfg_nxt.escape_check = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_mode   <= 1'b0;
      cfg_r.escape_body  <= 1'b1;
      cfg_r.escape_check <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept and classify
  bsfe_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ent    (q_ent)
  );

  // command queue
  bsfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_ent),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: byte sequencer with check and escaping
  bsfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/tb.sv @@
module tb;
  import bsfe_pkg::*;

  // opcode that the block has no use for
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int PAYLOAD_CAP  = 4096;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 1000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_CHECK_MODE;
  logic      cfg_wdata = 1'b0;

  byte_stuffed_frame_encoder #(
    .MAX_PAYLOAD(PAYLOAD_CAP)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // encoder state as seen from outside
  logic        mode_sum = 1'b0;
  logic        esc_body = 1'b1;
  logic        esc_check = 1'b1;
  logic [15:0] crc_acc = '0;
  logic [31:0] sum_acc = '0;
  logic [8:0]  half_word = '0;
  logic [11:0] decl_len = '0;
  int          pay_cnt = 0;
  logic        framing = 1'b0;
  logic        overflow = 1'b0;

  out_item_t step_bytes[$];
  out_item_t typed_bytes[$];
  out_item_t awaited_bytes[$];

  int mismatches = 0;
  int bytes_checked = 0;
  int cycle_count = 0;
  int gap_pct = 20;
  int stall_pct = 5;
  int stall_left = 0;

  // directed stimulus, expected bytes typed in where obvious
  typedef struct {
    in_item_t    item;
    bit          typed;
    int          n;
    logic [71:0] bytes;
    bit          mism;
  } stim_row_t;

  stim_row_t script[$];

  function automatic void add_row(input logic [1:0] op, input logic [15:0] cmd,
                                  input logic [11:0] len, input logic [7:0] data,
                                  input bit typed = 1'b0, input int n = 0,
                                  input logic [71:0] bytes = '0, input bit mism = 1'b0);
    stim_row_t row;
    row.item.opcode = op;
    row.item.command = cmd;
    row.item.payload_length = len;
    row.item.data_byte = data;
    row.typed = typed;
    row.n = n;
    row.bytes = bytes;
    row.mism = mism;
    script.insert(script.size(), row);
  endfunction

  // crc and word sum over one checked byte
  function automatic void absorb(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      crc_acc = {crc_acc[14:0], 1'b0} ^ ((crc_acc[15] ^ b[i]) ? CRC_POLY : 16'h0000);
    end
    if (half_word[8]) begin
      sum_acc = sum_acc + {16'h0000, half_word[7:0], b};
      half_word = '0;
    end else begin
      half_word = {1'b1, b};
    end
  endfunction

  function automatic void emit(input logic [7:0] b, input logic done, input logic mism);
    out_item_t r;
    r.out_byte = b;
    r.run_last = 1'b0;
    r.frame_done = done;
    r.length_mismatch = mism;
    step_bytes.insert(step_bytes.size(), r);
  endfunction

  function automatic void emit_stuffed(input logic [7:0] b, input logic esc,
                                       input logic mism);
    if (esc && (b == FLAG_BYTE || b == ESC_BYTE)) begin
      emit(ESC_BYTE, 1'b0, mism);
      emit(b ^ ESC_XOR, 1'b0, mism);
    end else begin
      emit(b, 1'b0, mism);
    end
  endfunction

  function automatic void emit_body(input logic [7:0] b);
    absorb(b);
    emit_stuffed(b, esc_body, 1'b0);
  endfunction

  // bytes that one input transaction should produce
  function automatic void encode_item(input in_item_t it);
    logic [12:0] hdr;
    logic [31:0] fold;
    logic [15:0] chk;
    logic        mism;
    step_bytes.delete();
    case (it.opcode)
      OP_START: begin
        hdr = ({1'b0, it.payload_length} + 13'd1) & ~13'd1;
        crc_acc = '0;
        sum_acc = '0;
        half_word = '0;
        decl_len = it.payload_length;
        pay_cnt = 0;
        overflow = 1'b0;
        framing = 1'b1;
        emit(FLAG_BYTE, 1'b0, 1'b0);
        emit_body(it.command[15:8]);
        emit_body(it.command[7:0]);
        emit_body({3'b000, hdr[12:8]});
        emit_body(hdr[7:0]);
      end
      OP_PAYLOAD: begin
        if (framing) begin
          // bytes past the cap vanish but spoil the length check
          if (pay_cnt >= PAYLOAD_CAP) begin
            overflow = 1'b1;
          end else begin
            pay_cnt++;
            emit_body(it.data_byte);
          end
        end
      end
      OP_END: begin
        if (framing) begin
          mism = overflow || (pay_cnt != int'(decl_len));
          // pad keeps the checked byte count even
          if (pay_cnt % 2 == 1) begin
            absorb(8'h00);
            emit(8'h00, 1'b0, mism);
          end
          if (mode_sum) begin
            fold = {16'h0000, sum_acc[31:16]} + {16'h0000, sum_acc[15:0]};
            fold = fold + (fold >> 16);
            chk = ~fold[15:0];
          end else begin
            chk = crc_acc;
          end
          emit_stuffed(chk[15:8], esc_body && esc_check, mism);
          emit_stuffed(chk[7:0], esc_body && esc_check, mism);
          emit(FLAG_BYTE, 1'b1, mism);
          framing = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].run_last = 1'b1;
  endfunction

  function automatic in_item_t scramble_item(input logic [1:0] op);
    in_item_t it;
    it.opcode = op;
    it.command = 16'($urandom);
    it.payload_length = 12'($urandom);
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  task automatic flag_error(input string msg);
    $display("mismatch at cycle %0d, byte %0d: %s", cycle_count, bytes_checked, msg);
    mismatches++;
  endtask

  // present one transaction, wait for it to be taken, then predict
  task automatic send_item(input in_item_t it, input bit use_typed);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_item(it);
    if (use_typed) step_bytes = typed_bytes;
    foreach (step_bytes[k]) awaited_bytes.insert(awaited_bytes.size(), step_bytes[k]);
  endtask

  // let everything drain, including transactions that give no bytes
  task automatic drain_to_idle();
    in_valid <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic cm, input logic eb, input logic ec);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHECK_MODE;
    cfg_wdata <= cm;
    @(posedge clk);
    cfg_index <= CFG_ESCAPE_BODY;
    cfg_wdata <= eb;
    @(posedge clk);
    cfg_index <= CFG_ESCAPE_CHECK;
    cfg_wdata <= ec;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_sum = cm;
    esc_body = eb;
    esc_check = ec;
  endtask

  // output side: compare each byte, stall in bursts
  always @(posedge clk) begin : byte_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_bytes.size() == 0) begin
        flag_error($sformatf("byte %02h with nothing expected", out_data.out_byte));
      end else begin
        want = awaited_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte)
          flag_error($sformatf("out_byte %02h, want %02h", out_data.out_byte, want.out_byte));
        if (out_data.run_last !== want.run_last)
          flag_error($sformatf("run_last %b, want %b", out_data.run_last, want.run_last));
        if (out_data.frame_done !== want.frame_done)
          flag_error($sformatf("frame_done %b, want %b", out_data.frame_done,
                               want.frame_done));
        if (out_data.length_mismatch !== want.length_mismatch)
          flag_error($sformatf("length_mismatch %b, want %b", out_data.length_mismatch,
                               want.length_mismatch));
      end
      bytes_checked++;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               awaited_bytes.size());
      $display("byte_stuffed_frame_encoder verification failed");
      $finish;
    end
  end

  initial begin
    in_item_t   it;
    out_item_t  r;
    logic [2:0] cfg_bits;
    int         sent;
    int         decl;
    int         npay;

    // idle transactions, empty frame, escapes, extremes, abandoned frame, pads
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'hFF, 1'b1, 0);
    add_row(OP_END, 16'h0000, 12'h000, 8'h00, 1'b1, 0);
    add_row(OP_UNUSED, 16'hFFFF, 12'hFFF, 8'hFF, 1'b1, 0);
    add_row(OP_START, 16'h0000, 12'h000, 8'h00, 1'b1, 5, 72'h7E_00_00_00_00);
    add_row(OP_END, 16'h0000, 12'h000, 8'h00, 1'b1, 3, 72'h00_00_7E, 1'b0);
    add_row(OP_START, 16'h7E7D, 12'hFFF, 8'h00, 1'b1, 7, 72'h7E_7D_5E_7D_5D_10_00);
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'h7E, 1'b1, 2, 72'h7D_5E);
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'h7D, 1'b1, 2, 72'h7D_5D);
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'hFF, 1'b1, 1, 72'hFF);
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'h00, 1'b1, 1, 72'h00);
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'h5A);
    add_row(OP_END, 16'h0000, 12'h000, 8'h00);
    add_row(OP_START, 16'hFFFF, 12'h001, 8'h00, 1'b1, 5, 72'h7E_FF_FF_00_02);
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'hA5, 1'b1, 1, 72'hA5);
    add_row(OP_START, 16'h1234, 12'h002, 8'h00, 1'b1, 5, 72'h7E_12_34_00_02);
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'h7E);
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'h7D);
    add_row(OP_END, 16'h0000, 12'h000, 8'h00);
    add_row(OP_START, 16'h8001, 12'h003, 8'h00, 1'b1, 5, 72'h7E_80_01_00_04);
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'h3C);
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'hC3);
    add_row(OP_PAYLOAD, 16'h0000, 12'h000, 8'h7E);
    add_row(OP_END, 16'h0000, 12'h000, 8'h00);
    add_row(OP_END, 16'h0000, 12'h000, 8'h00, 1'b1, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset configuration
    foreach (script[i]) begin
      typed_bytes.delete();
      for (int k = 0; k < script[i].n; k++) begin
        r.out_byte = script[i].bytes[8 * (script[i].n - 1 - k) +: 8];
        r.run_last = (k == script[i].n - 1);
        r.frame_done = r.run_last && (script[i].item.opcode == OP_END);
        r.length_mismatch = script[i].mism;
        typed_bytes.insert(typed_bytes.size(), r);
      end
      send_item(script[i].item, script[i].typed);
    end

    // random frames, one phase per configuration, the last one without idling
    for (int p = 0; p < 9; p++) begin
      drain_to_idle();
      cfg_bits = (p < 8) ? 3'(p) : 3'($urandom);
      apply_config(cfg_bits[2], cfg_bits[1], cfg_bits[0]);
      if (p == 8) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            gap_pct = 0;
            stall_pct = 0;
          end
          1: begin
            gap_pct = 20;
            stall_pct = 4;
          end
          default: begin
            gap_pct = 50;
            stall_pct = 12;
          end
        endcase
      end
      sent = 0;
      while (sent < 16) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray transaction between frames
          case ($urandom_range(0, 2))
            0: it = scramble_item(OP_PAYLOAD);
            1: it = scramble_item(OP_END);
            default: it = scramble_item(OP_UNUSED);
          endcase
          send_item(it, 1'b0);
        end else begin
          decl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 12);
          npay = ($urandom_range(0, 4) == 0 || decl > 14) ? $urandom_range(0, 14) : decl;
          it = scramble_item(OP_START);
          it.payload_length = 12'(decl);
          send_item(it, 1'b0);
          for (int k = 0; k < npay; k++) begin
            it = scramble_item(OP_PAYLOAD);
            if ($urandom_range(0, 5) == 0) it.data_byte = $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
            send_item(it, 1'b0);
          end
          // now and then the frame is left open and the next start abandons it
          if ($urandom_range(0, 11) != 0) send_item(scramble_item(OP_END), 1'b0);
          sent += npay + 2;
        end
      end
    end

    drain_to_idle();
    if (mismatches == 0) begin
      $display("byte_stuffed_frame_encoder verification clean");
    end else begin
      $display("byte_stuffed_frame_encoder verification failed");
    end
    $finish;
  end

endmodule

@@ byte_stuffed_frame_encoder.f @@
rtl/bsfe_pkg.sv
rtl/bsfe_front.sv
rtl/bsfe_queue.sv
rtl/bsfe_back.sv
rtl/byte_stuffed_frame_encoder.sv
tb/tb.sv
